// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker file of the parity engine.
// Expects signals named clk and arst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define R5P_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define R5P_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/r5p_pkg.sv -----
// Package of the RAID-5 stripe parity engine: field widths, codes and shared types.
// Has no dependencies; every other file of the block but assert_macros.svh uses it.
`default_nettype none

package r5p_pkg;

	localparam int DISK_COUNT_DEF  = 4;
	localparam int BLOCK_BYTES_DEF = 512;

	localparam int LANE_COUNT = 4;
	localparam int LANE_IDX_W = 2;
	localparam int BYTE_W     = 8;
	localparam int STRIPE_W   = 16;
	localparam int POS_W      = 9;
	localparam int LANES_W    = LANE_COUNT * BYTE_W;
	localparam int FAIL_W     = 4;
	localparam int KEEP_W     = 3;
	localparam int FLEN_W     = 24;

	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;
	localparam int REG_IDX_W  = 1;

	localparam logic [REG_IDX_W-1:0] REG_FILE_LENGTH = 1'b0;

	localparam logic STATUS_OK         = 1'b0;
	localparam logic STATUS_MULTI_FAIL = 1'b1;

	typedef enum logic {
		OP_STORE = 1'b0,
		OP_READ  = 1'b1
	} op_t;

	typedef logic [LANE_COUNT-1:0][BYTE_W-1:0] lane_bytes_t;

	typedef struct packed {
		op_t                   op;
		logic [LANE_COUNT-1:0] file_ok;
		logic [FAIL_W-1:0]     fail_mask;
	} ctl_t;

	typedef struct packed {
		logic [BYTE_W-1:0] val;
		logic              failed;
		logic              is_parity;
	} lane_res_t;

endpackage

`default_nettype wire

// ----- rtl/core/r5p_channels.sv -----
// Handshake channels of the parity engine: the column word in and the result word out.
// Depends on r5p_pkg for the field widths.
`default_nettype none

interface r5p_in_if;
	logic                             valid;
	logic                             ready;
	logic                             op;
	logic [r5p_pkg::STRIPE_W-1:0]     stripe;
	logic [r5p_pkg::POS_W-1:0]        byte_pos;
	logic [r5p_pkg::LANES_W-1:0]      lanes_in;
	logic [r5p_pkg::FAIL_W-1:0]       fail_mask;

	modport source (output valid, op, stripe, byte_pos, lanes_in, fail_mask, input ready);
	modport sink (input valid, op, stripe, byte_pos, lanes_in, fail_mask, output ready);
endinterface

interface r5p_out_if;
	logic                             valid;
	logic                             ready;
	logic [r5p_pkg::LANES_W-1:0]      lanes_out;
	logic [r5p_pkg::KEEP_W-1:0]       keep_mask;
	logic                             status;

	modport source (output valid, lanes_out, keep_mask, status, input ready);
	modport sink (input valid, lanes_out, keep_mask, status, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/r5p_cfg_regs.sv -----
// APB register block of the parity engine; holds the file length register.
// Depends on r5p_pkg for the address map and widths.
`default_nettype none

module r5p_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [r5p_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [r5p_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [r5p_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready,
	output logic [r5p_pkg::FLEN_W-1:0]       file_length
);

	logic [r5p_pkg::REG_IDX_W-1:0] reg_idx;
	logic                          wr_en;
	logic [r5p_pkg::FLEN_W-1:0]    file_length_q;

	assign reg_idx = paddr[r5p_pkg::APB_ADDR_W-1 -: r5p_pkg::REG_IDX_W];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_length_q <= '0;
		end else if (wr_en && (reg_idx == r5p_pkg::REG_FILE_LENGTH)) begin
			file_length_q <= pwdata[r5p_pkg::FLEN_W-1:0];
		end
	end

	always_comb begin
		unique case (reg_idx)
			r5p_pkg::REG_FILE_LENGTH: begin
				prdata = r5p_pkg::APB_DATA_W'(file_length_q);
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

	assign file_length = file_length_q;

endmodule

`default_nettype wire

// ----- rtl/core/r5p_locate.sv -----
// Stripe locator: finds the parity disk and which data slots hold file bytes.
// First stage registers the reciprocal quotient and the byte offset; depends on r5p_pkg.
`default_nettype none

module r5p_locate #(
	parameter int DISK_COUNT  = r5p_pkg::DISK_COUNT_DEF,
	parameter int BLOCK_BYTES = r5p_pkg::BLOCK_BYTES_DEF,
	localparam int DISK_W     = $clog2(DISK_COUNT)
) (
	input  logic                            clk,
	input  logic                            load,
	input  logic [r5p_pkg::STRIPE_W-1:0]    stripe,
	input  logic [r5p_pkg::POS_W-1:0]       byte_pos,
	input  logic [r5p_pkg::FLEN_W-1:0]      file_length,
	output logic [DISK_W-1:0]               parity,
	output logic [r5p_pkg::LANE_COUNT-1:0]  file_ok
);

	localparam int STRIPE_W     = r5p_pkg::STRIPE_W;
	localparam int STRIPE_BYTES = (DISK_COUNT - 1) * BLOCK_BYTES;
	localparam int OFF_W        = STRIPE_W + $clog2(STRIPE_BYTES) + 2;
	localparam int CMP_W        = (OFF_W > r5p_pkg::FLEN_W) ? OFF_W : r5p_pkg::FLEN_W;
	localparam int MOD_SHIFT    = STRIPE_W + $clog2(DISK_COUNT);
	localparam longint unsigned MOD_MULT =
		((64'd1 << MOD_SHIFT) + 64'(DISK_COUNT) - 64'd1) / 64'(DISK_COUNT);
	localparam int MOD_MULT_W   = MOD_SHIFT + 1;
	localparam int PROD_W       = STRIPE_W + MOD_MULT_W;
	localparam int SLOT_OUT     = (DISK_COUNT - 1 < r5p_pkg::LANE_COUNT) ?
		(DISK_COUNT - 1) : r5p_pkg::LANE_COUNT;

	logic [PROD_W-1:0]   recip;
	logic [STRIPE_W-1:0] stripe_s1;
	logic [STRIPE_W-1:0] quot_s1;
	logic [OFF_W-1:0]    base_s1;
	logic                pos_ok_s1;
	logic [STRIPE_W-1:0] rem;

	assign recip = PROD_W'(stripe) * PROD_W'(MOD_MULT);

	always_ff @(posedge clk) begin
		if (load) begin
			stripe_s1 <= stripe;
			quot_s1   <= recip[MOD_SHIFT +: STRIPE_W];
			base_s1   <= OFF_W'(stripe) * OFF_W'(STRIPE_BYTES) + OFF_W'(byte_pos);
			pos_ok_s1 <= 32'(byte_pos) < 32'(BLOCK_BYTES);
		end
	end

	assign rem    = stripe_s1 - quot_s1 * STRIPE_W'(DISK_COUNT);
	assign parity = DISK_W'(DISK_COUNT - 1) - rem[DISK_W-1:0];

	always_comb begin
		file_ok = '0;
		for (int j = 0; j < SLOT_OUT; j++) begin
			file_ok[j] = pos_ok_s1 &&
				((CMP_W'(base_s1) + CMP_W'(j * BLOCK_BYTES)) < CMP_W'(file_length));
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/r5p_lane.sv -----
// One disk lane: picks the byte this disk contributes to the column XOR.
// Store lanes map a data slot onto the disk; read lanes drop a failed disk. Uses r5p_pkg.
`default_nettype none

module r5p_lane #(
	parameter int DISK_COUNT = r5p_pkg::DISK_COUNT_DEF,
	parameter int DISK_IDX   = 0,
	localparam int DISK_W    = $clog2(DISK_COUNT)
) (
	input  logic [DISK_W-1:0]         parity,
	input  r5p_pkg::ctl_t             ctl,
	input  r5p_pkg::lane_bytes_t      lanes,
	output r5p_pkg::lane_res_t        res
);

	localparam int IDX_CLAMP = DISK_IDX % r5p_pkg::LANE_COUNT;
	localparam bit HAS_LANE  = DISK_IDX < r5p_pkg::LANE_COUNT;
	localparam int LIW       = r5p_pkg::LANE_IDX_W;

	logic [DISK_W-1:0]          k_idx;
	logic [DISK_W-1:0]          slot;
	logic                       is_par;
	logic                       has_data;
	logic                       failed;
	logic [r5p_pkg::BYTE_W-1:0] data_byte;
	logic [r5p_pkg::BYTE_W-1:0] in_byte;

	assign k_idx  = DISK_W'(DISK_IDX);
	assign is_par = parity == k_idx;
	assign slot   = (k_idx > parity) ? (k_idx - DISK_W'(1)) : k_idx;

	assign has_data = !is_par &&
		({1'b0, slot} < (DISK_W + 1)'(r5p_pkg::LANE_COUNT)) &&
		ctl.file_ok[slot[LIW-1:0]];
	assign data_byte = has_data ? lanes[slot[LIW-1:0]] : '0;

	assign in_byte = HAS_LANE ? lanes[LIW'(IDX_CLAMP)] : '0;
	assign failed  = (ctl.op == r5p_pkg::OP_READ) && HAS_LANE &&
		ctl.fail_mask[LIW'(IDX_CLAMP)];

	always_comb begin
		res.is_parity = is_par;
		res.failed    = failed;
		if (ctl.op == r5p_pkg::OP_STORE) begin
			res.val = data_byte;
		end else begin
			res.val = failed ? '0 : in_byte;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/r5p_merge.sv -----
// Merge stage: XORs the lane bytes, places parity or the rebuilt byte, orders the result.
// Counts failed disks for the status flag. Depends on r5p_pkg.
`default_nettype none

module r5p_merge #(
	parameter int DISK_COUNT = r5p_pkg::DISK_COUNT_DEF,
	localparam int DISK_W    = $clog2(DISK_COUNT)
) (
	input  r5p_pkg::lane_res_t                res [DISK_COUNT],
	input  logic [DISK_W-1:0]                 parity,
	input  r5p_pkg::ctl_t                     ctl,
	output r5p_pkg::lane_bytes_t              lanes_out,
	output logic [r5p_pkg::KEEP_W-1:0]        keep_mask,
	output logic                              status
);

	localparam int CNT_W     = $clog2(DISK_COUNT + 1);
	localparam int OUT_DISKS = (DISK_COUNT < r5p_pkg::LANE_COUNT) ?
		DISK_COUNT : r5p_pkg::LANE_COUNT;
	localparam int SLOT_OUT  = (DISK_COUNT - 1 < r5p_pkg::LANE_COUNT) ?
		(DISK_COUNT - 1) : r5p_pkg::LANE_COUNT;

	logic [r5p_pkg::BYTE_W-1:0] acc;
	logic [CNT_W-1:0]           fail_cnt;
	logic [r5p_pkg::BYTE_W-1:0] disk_byte [DISK_COUNT];
	r5p_pkg::lane_bytes_t       store_bytes;
	r5p_pkg::lane_bytes_t       read_bytes;
	logic [DISK_W-1:0]          src;
	logic                       pick;

	always_comb begin
		acc      = '0;
		fail_cnt = '0;
		for (int k = 0; k < DISK_COUNT; k++) begin
			acc      = acc ^ res[k].val;
			fail_cnt = fail_cnt + CNT_W'(res[k].failed);
		end

		for (int k = 0; k < DISK_COUNT; k++) begin
			pick = (ctl.op == r5p_pkg::OP_STORE) ? res[k].is_parity : res[k].failed;
			disk_byte[k] = pick ? acc : res[k].val;
		end

		store_bytes = '0;
		for (int k = 0; k < OUT_DISKS; k++) begin
			store_bytes[k] = disk_byte[k];
		end

		read_bytes = '0;
		src        = '0;
		for (int j = 0; j < SLOT_OUT; j++) begin
			src = (DISK_W'(j) < parity) ? DISK_W'(j) : DISK_W'(j + 1);
			read_bytes[j] = ctl.file_ok[j] ? disk_byte[src] : '0;
		end

		status = ((ctl.op == r5p_pkg::OP_READ) && (fail_cnt > CNT_W'(1))) ?
			r5p_pkg::STATUS_MULTI_FAIL : r5p_pkg::STATUS_OK;

		if (status == r5p_pkg::STATUS_MULTI_FAIL) begin
			lanes_out = '0;
			keep_mask = '0;
		end else begin
			lanes_out = (ctl.op == r5p_pkg::OP_STORE) ? store_bytes : read_bytes;
			keep_mask = ctl.file_ok[r5p_pkg::KEEP_W-1:0];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/raid5_stripe_parity_engine.sv -----
// Top level of the RAID-5 stripe parity engine: locator, disk lanes, merge and APB registers.
// Depends on r5p_pkg, r5p_channels, r5p_cfg_regs, r5p_locate, r5p_lane and r5p_merge.
//
// Each word in carries one byte column of one stripe and gives exactly one result word.
// A store returns the disk bytes with the rotating XOR parity in place; a read rebuilds
// a single failed disk and returns the data bytes by slot, or status 1 with zeroed data
// when two or more disks failed. Bytes at or beyond the file_length register (APB
// address 0) count as zero and clear their keep_mask bit. The engine takes one word
// per cycle while the output is not stalled; a locator stage computes the stripe's
// parity disk by reciprocal multiplication and the byte offset, a second stage checks
// the slots against the file length, and the lanes with their merge feed the output
// register. Input ready drops only while the output register holds an untaken result.
`default_nettype none

module raid5_stripe_parity_engine #(
	parameter int DISK_COUNT  = r5p_pkg::DISK_COUNT_DEF,
	parameter int BLOCK_BYTES = r5p_pkg::BLOCK_BYTES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	r5p_in_if.sink                           item_in,
	r5p_out_if.source                        result_out,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [r5p_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [r5p_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [r5p_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready
);

	localparam int DISK_W = $clog2(DISK_COUNT);

	logic                            en_s1;
	logic                            en_s2;
	logic                            en_s3;
	logic                            valid_s1;
	logic                            valid_s2;
	logic                            valid_s3;
	logic [r5p_pkg::FLEN_W-1:0]      file_length;

	r5p_pkg::op_t                    op_s1;
	r5p_pkg::lane_bytes_t            lanes_s1;
	logic [r5p_pkg::FAIL_W-1:0]      fail_s1;
	logic [DISK_W-1:0]               parity_loc;
	logic [r5p_pkg::LANE_COUNT-1:0]  file_ok_loc;

	r5p_pkg::ctl_t                   ctl_s2;
	logic [DISK_W-1:0]               parity_s2;
	r5p_pkg::lane_bytes_t            lanes_s2;

	r5p_pkg::lane_res_t              lane_res [DISK_COUNT];
	r5p_pkg::lane_bytes_t            merged_lanes;
	logic [r5p_pkg::KEEP_W-1:0]      merged_keep;
	logic                            merged_status;

	r5p_pkg::lane_bytes_t            lanes_out_s3;
	logic [r5p_pkg::KEEP_W-1:0]      keep_s3;
	logic                            status_s3;

	assign en_s3 = !valid_s3 || result_out.ready;
	assign en_s2 = !valid_s2 || en_s3;
	assign en_s1 = !valid_s1 || en_s2;

	assign item_in.ready = en_s1;

	r5p_cfg_regs u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.file_length (file_length)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= item_in.valid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (en_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	r5p_locate #(
		.DISK_COUNT  (DISK_COUNT),
		.BLOCK_BYTES (BLOCK_BYTES)
	) u_locate (
		.clk         (clk),
		.load        (en_s1),
		.stripe      (item_in.stripe),
		.byte_pos    (item_in.byte_pos),
		.file_length (file_length),
		.parity      (parity_loc),
		.file_ok     (file_ok_loc)
	);

	always_ff @(posedge clk) begin
		if (en_s1) begin
			op_s1    <= r5p_pkg::op_t'(item_in.op);
			lanes_s1 <= item_in.lanes_in;
			fail_s1  <= item_in.fail_mask;
		end
		if (en_s2) begin
			ctl_s2.op        <= op_s1;
			ctl_s2.file_ok   <= file_ok_loc;
			ctl_s2.fail_mask <= fail_s1;
			parity_s2        <= parity_loc;
			lanes_s2         <= lanes_s1;
		end
		if (en_s3) begin
			lanes_out_s3 <= merged_lanes;
			keep_s3      <= merged_keep;
			status_s3    <= merged_status;
		end
	end

	for (genvar k = 0; k < DISK_COUNT; k++) begin : g_lane
		r5p_lane #(
			.DISK_COUNT (DISK_COUNT),
			.DISK_IDX   (k)
		) u_lane (
			.parity (parity_s2),
			.ctl    (ctl_s2),
			.lanes  (lanes_s2),
			.res    (lane_res[k])
		);
	end

	r5p_merge #(
		.DISK_COUNT (DISK_COUNT)
	) u_merge (
		.res       (lane_res),
		.parity    (parity_s2),
		.ctl       (ctl_s2),
		.lanes_out (merged_lanes),
		.keep_mask (merged_keep),
		.status    (merged_status)
	);

	assign result_out.valid     = valid_s3;
	assign result_out.lanes_out = lanes_out_s3;
	assign result_out.keep_mask = keep_s3;
	assign result_out.status    = status_s3;

endmodule

`default_nettype wire

// ----- rtl/core/r5p_checker.sv -----
// Port-level checker of the parity engine, bound to the top level.
// Depends on r5p_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module r5p_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           in_valid,
	input wire logic                           in_ready,
	input wire logic                           out_valid,
	input wire logic                           out_ready,
	input wire logic [r5p_pkg::LANES_W-1:0]    out_lanes,
	input wire logic [r5p_pkg::KEEP_W-1:0]     out_keep,
	input wire logic                           out_status
);

	logic in_acc;

	assign in_acc = in_valid && in_ready;

	// The pipeline only pushes back when a finished result sits untaken.
	`R5P_ASSERT_IMPL(a_ready_only_on_stall, !in_ready, out_valid && !out_ready, "input stalled without a stalled result")

	// A multiple failure reports no data at all.
	`R5P_ASSERT_IMPL(a_fail_clears_data, out_valid && (out_status == r5p_pkg::STATUS_MULTI_FAIL), (out_lanes == '0) && (out_keep == '0), "multi-failure result carries data")

	// If no word was taken in early enough to reach the output and no result was shown since, none can appear.
	`R5P_ASSERT_IMPL(a_no_invented_word, !$past(in_acc, 3) && !$past(out_valid, 1) && !$past(out_valid, 2) && !$past(out_valid, 3), !out_valid, "result word without an input word")

	`R5P_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_lanes) && $stable(out_keep) && $stable(out_status), "stalled result changed")

endmodule

bind raid5_stripe_parity_engine r5p_checker u_r5p_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (item_in.valid),
	.in_ready   (item_in.ready),
	.out_valid  (result_out.valid),
	.out_ready  (result_out.ready),
	.out_lanes  (result_out.lanes_out),
	.out_keep   (result_out.keep_mask),
	.out_status (result_out.status)
);

`default_nettype wire

// ----- test/raid5_stripe_parity_engine_tb.sv -----
// Testbench of the RAID-5 stripe parity engine: random and directed store and read columns
// against a predictor of the parity placement, rebuild and file-length masking.
// Depends on r5p_pkg, r5p_channels and the raid5_stripe_parity_engine top level.
`timescale 1ns / 1ps

module raid5_stripe_parity_engine_tb;

	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned PHASE_WORDS = 155;
	localparam logic [r5p_pkg::APB_ADDR_W-1:0] FILE_LENGTH_ADDR =
		{r5p_pkg::REG_FILE_LENGTH, 2'b00};

	typedef struct packed {
		r5p_pkg::op_t                 op;
		logic [r5p_pkg::STRIPE_W-1:0] stripe;
		logic [r5p_pkg::POS_W-1:0]    byte_pos;
		r5p_pkg::lane_bytes_t         lanes;
		logic [r5p_pkg::FAIL_W-1:0]   fail_mask;
	} column_word_t;

	typedef struct packed {
		r5p_pkg::lane_bytes_t       lanes;
		logic [r5p_pkg::KEEP_W-1:0] keep;
		logic                       status;
	} column_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [r5p_pkg::APB_ADDR_W-1:0] paddr;
	logic [r5p_pkg::APB_DATA_W-1:0] pwdata;
	logic [r5p_pkg::APB_DATA_W-1:0] prdata;
	logic pready;

	r5p_in_if  column_if ();
	r5p_out_if parity_if ();

	raid5_stripe_parity_engine u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_in    (column_if),
		.result_out (parity_if),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	always #1 clk = ~clk;

	column_word_t   pending_columns[$];
	column_result_t expected_columns[$];
	column_word_t   next_column;
	column_word_t   taken_column;
	column_result_t due_column;
	column_result_t check_column;
	logic [r5p_pkg::FLEN_W-1:0] file_length_now;
	int unsigned send_gap;
	int unsigned recv_stall;
	int unsigned send_idle_odds;
	int unsigned recv_idle_odds;
	int unsigned stall_cycles;
	int unsigned mismatches;
	int unsigned n_stores;
	int unsigned n_reads;
	int unsigned n_rebuilds;
	int unsigned n_multi_fail;
	int unsigned n_partial_keep;
	int unsigned n_lengths;

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		$display("MISMATCH %0s: got %h, expected %h at %0t", field, got, want, $time);
		mismatches++;
	endtask

	function automatic logic slot_holds_file_byte(input logic [r5p_pkg::STRIPE_W-1:0] stripe,
			input logic [r5p_pkg::POS_W-1:0] pos, input int unsigned slot,
			input logic [r5p_pkg::FLEN_W-1:0] flen);
		logic [31:0] offset;
		if (pos >= r5p_pkg::BLOCK_BYTES_DEF)
			return 1'b0;
		offset = (32'(stripe) * 32'(r5p_pkg::DISK_COUNT_DEF - 1) + 32'(slot))
			* 32'(r5p_pkg::BLOCK_BYTES_DEF) + 32'(pos);
		return offset < 32'(flen);
	endfunction

	function automatic column_result_t predict_column(input column_word_t w,
			input logic [r5p_pkg::FLEN_W-1:0] flen);
		column_result_t r;
		r5p_pkg::lane_bytes_t disk;
		logic [r5p_pkg::BYTE_W-1:0] acc;
		int unsigned par_idx;
		int unsigned slot;
		int unsigned fails;
		int unsigned lost;
		r = '0;
		disk = '0;
		acc = '0;
		slot = 0;
		fails = 0;
		lost = 0;
		par_idx = r5p_pkg::DISK_COUNT_DEF - 1 - (32'(w.stripe) % r5p_pkg::DISK_COUNT_DEF);
		r.status = r5p_pkg::STATUS_OK;
		if (w.op == r5p_pkg::OP_STORE) begin
			for (int unsigned k = 0; k < r5p_pkg::DISK_COUNT_DEF; k++) begin
				if (k != par_idx) begin
					if (slot_holds_file_byte(w.stripe, w.byte_pos, slot, flen)) begin
						disk[k] = w.lanes[slot];
						r.keep[slot] = 1'b1;
					end
					acc ^= disk[k];
					slot++;
				end
			end
			disk[par_idx] = acc;
			r.lanes = disk;
		end else begin
			for (int unsigned k = 0; k < r5p_pkg::DISK_COUNT_DEF; k++) begin
				if (w.fail_mask[k]) begin
					fails++;
					lost = k;
				end else begin
					disk[k] = w.lanes[k];
				end
				acc ^= disk[k];
			end
			if (fails > 1) begin
				r.status = r5p_pkg::STATUS_MULTI_FAIL;
			end else begin
				if (fails == 1)
					disk[lost] = acc;
				for (int unsigned k = 0; k < r5p_pkg::DISK_COUNT_DEF; k++) begin
					if (k != par_idx) begin
						if (slot_holds_file_byte(w.stripe, w.byte_pos, slot, flen)) begin
							r.lanes[slot] = disk[k];
							r.keep[slot] = 1'b1;
						end
						slot++;
					end
				end
			end
		end
		return r;
	endfunction

	function automatic column_word_t make_column(input r5p_pkg::op_t op,
			input logic [r5p_pkg::STRIPE_W-1:0] stripe,
			input logic [r5p_pkg::POS_W-1:0] pos, input logic [r5p_pkg::LANES_W-1:0] lanes,
			input logic [r5p_pkg::FAIL_W-1:0] fails);
		column_word_t w;
		w.op = op;
		w.stripe = stripe;
		w.byte_pos = pos;
		w.lanes = lanes;
		w.fail_mask = fails;
		return w;
	endfunction

	// Most stripes sit around the one holding the end of the file, so the
	// keep mask is cut at every slot position.
	function automatic column_word_t random_column(input logic [r5p_pkg::FLEN_W-1:0] flen);
		column_word_t w;
		int unsigned bound_stripe;
		int unsigned pick;
		bound_stripe = 32'(flen) / (r5p_pkg::BLOCK_BYTES_DEF * (r5p_pkg::DISK_COUNT_DEF - 1));
		w.op = r5p_pkg::op_t'($urandom_range(0, 1));
		pick = $urandom_range(0, 99);
		if (pick < 70)
			w.stripe = r5p_pkg::STRIPE_W'(bound_stripe + $urandom_range(0, 4) - 2);
		else if (pick < 85)
			w.stripe = r5p_pkg::STRIPE_W'($urandom_range(0, 15));
		else
			w.stripe = r5p_pkg::STRIPE_W'($urandom());
		pick = $urandom_range(0, 99);
		if (pick < 50)
			w.byte_pos = r5p_pkg::POS_W'($urandom());
		else if (pick < 70)
			w.byte_pos = r5p_pkg::POS_W'(32'(flen) % r5p_pkg::BLOCK_BYTES_DEF
				+ $urandom_range(0, 2) - 1);
		else if (pick < 85)
			w.byte_pos = '0;
		else
			w.byte_pos = r5p_pkg::POS_W'(r5p_pkg::BLOCK_BYTES_DEF - 1);
		w.lanes = r5p_pkg::LANES_W'($urandom());
		pick = $urandom_range(0, 99);
		if (pick < 40)
			w.fail_mask = '0;
		else if (pick < 80)
			w.fail_mask = r5p_pkg::FAIL_W'(1) << $urandom_range(0, r5p_pkg::FAIL_W - 1);
		else
			w.fail_mask = r5p_pkg::FAIL_W'($urandom());
		return w;
	endfunction

	task automatic set_file_length(input logic [r5p_pkg::FLEN_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= FILE_LENGTH_ADDR;
		pwdata <= r5p_pkg::APB_DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		file_length_now = value;
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		if (prdata !== r5p_pkg::APB_DATA_W'(value))
			report_mismatch("file_length read back", prdata, r5p_pkg::APB_DATA_W'(value));
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		n_lengths++;
	endtask

	task automatic wait_drained();
		while (pending_columns.size() != 0 || column_if.valid || expected_columns.size() != 0)
			@(negedge clk);
		repeat (6) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic queue_random_columns(input int unsigned count);
		repeat (count) pending_columns.push_back(random_column(file_length_now));
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			column_if.valid <= 1'b0;
			column_if.op <= r5p_pkg::OP_STORE;
			column_if.stripe <= '0;
			column_if.byte_pos <= '0;
			column_if.lanes_in <= '0;
			column_if.fail_mask <= '0;
			send_gap <= 0;
		end else if (!column_if.valid || column_if.ready) begin
			if (send_gap != 0) begin
				column_if.valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pending_columns.size() != 0) begin
				next_column = pending_columns.pop_front();
				column_if.valid <= 1'b1;
				column_if.op <= next_column.op;
				column_if.stripe <= next_column.stripe;
				column_if.byte_pos <= next_column.byte_pos;
				column_if.lanes_in <= next_column.lanes;
				column_if.fail_mask <= next_column.fail_mask;
				if (send_idle_odds != 0 && $urandom_range(1, send_idle_odds) == 1)
					send_gap <= $urandom_range(1, 16);
			end else begin
				column_if.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			parity_if.ready <= 1'b0;
			recv_stall <= 0;
		end else if (recv_stall != 0) begin
			parity_if.ready <= 1'b0;
			recv_stall <= recv_stall - 1;
		end else begin
			parity_if.ready <= 1'b1;
			if (recv_idle_odds != 0 && $urandom_range(1, recv_idle_odds) == 1)
				recv_stall <= $urandom_range(1, 16);
		end
	end

	always @(posedge clk) begin
		if (arst_n && column_if.valid && column_if.ready) begin
			taken_column.op = r5p_pkg::op_t'(column_if.op);
			taken_column.stripe = column_if.stripe;
			taken_column.byte_pos = column_if.byte_pos;
			taken_column.lanes = column_if.lanes_in;
			taken_column.fail_mask = column_if.fail_mask;
			due_column = predict_column(taken_column, file_length_now);
			expected_columns.push_back(due_column);
			if (taken_column.op == r5p_pkg::OP_STORE)
				n_stores++;
			else
				n_reads++;
			if (taken_column.op == r5p_pkg::OP_READ && $countones(taken_column.fail_mask) == 1)
				n_rebuilds++;
			if (due_column.status == r5p_pkg::STATUS_MULTI_FAIL)
				n_multi_fail++;
			if (due_column.keep != '0 && due_column.keep != '1)
				n_partial_keep++;
		end
	end

	always @(posedge clk) begin
		if (arst_n && parity_if.valid && parity_if.ready) begin
			if (expected_columns.size() == 0) begin
				report_mismatch("result word with none expected", parity_if.lanes_out, '0);
			end else begin
				check_column = expected_columns.pop_front();
				if (parity_if.lanes_out !== check_column.lanes)
					report_mismatch("lanes_out", parity_if.lanes_out, check_column.lanes);
				if (parity_if.keep_mask !== check_column.keep)
					report_mismatch("keep_mask", 32'(parity_if.keep_mask),
						32'(check_column.keep));
				if (parity_if.status !== check_column.status)
					report_mismatch("status", 32'(parity_if.status), 32'(check_column.status));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			stall_cycles <= 0;
		end else begin
			if ((column_if.valid && column_if.ready) || (parity_if.valid && parity_if.ready)
					|| psel)
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("watchdog: no word moved for %0d cycles", stall_cycles);
				$display("raid5_stripe_parity_engine test failed");
				$finish;
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		file_length_now = '0;
		send_idle_odds = 6;
		recv_idle_odds = 8;
		mismatches = 0;
		n_stores = 0;
		n_reads = 0;
		n_rebuilds = 0;
		n_multi_fail = 0;
		n_partial_keep = 0;
		n_lengths = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// With the reset length of zero no byte belongs to the file.
		pending_columns.push_back(make_column(r5p_pkg::OP_STORE, 16'd0, 9'd0, 32'hA1B2C3D4,
			4'h0));
		pending_columns.push_back(make_column(r5p_pkg::OP_READ, 16'd2, 9'd17, 32'h5566AA99,
			4'h2));
		queue_random_columns(4);
		wait_drained();

		set_file_length(24'd8380);
		@(negedge clk);
		for (int s = 0; s < 4; s++)
			pending_columns.push_back(make_column(r5p_pkg::OP_STORE, 16'(s), 9'd0,
				32'h11223344, 4'h0));
		pending_columns.push_back(make_column(r5p_pkg::OP_STORE, 16'd0, 9'd511, 32'hFFFFFFFF,
			4'hF));
		pending_columns.push_back(make_column(r5p_pkg::OP_STORE, 16'd1, 9'd300, 32'h00000000,
			4'h0));
		pending_columns.push_back(make_column(r5p_pkg::OP_STORE, 16'd5, 9'd187, 32'hDEADBEEF,
			4'h0));
		pending_columns.push_back(make_column(r5p_pkg::OP_STORE, 16'd5, 9'd188, 32'hDEADBEEF,
			4'h0));
		pending_columns.push_back(make_column(r5p_pkg::OP_STORE, 16'hFFFF, 9'd511,
			32'hFFFFFFFF, 4'hF));
		pending_columns.push_back(make_column(r5p_pkg::OP_READ, 16'd0, 9'd0, 32'hFFFFFFFF,
			4'h0));
		pending_columns.push_back(make_column(r5p_pkg::OP_READ, 16'd0, 9'd5, 32'h12345678,
			4'h1));
		pending_columns.push_back(make_column(r5p_pkg::OP_READ, 16'd1, 9'd6, 32'h9ABCDEF0,
			4'h2));
		pending_columns.push_back(make_column(r5p_pkg::OP_READ, 16'd2, 9'd7, 32'h0F1E2D3C,
			4'h4));
		pending_columns.push_back(make_column(r5p_pkg::OP_READ, 16'd3, 9'd511, 32'hC3A5965A,
			4'h8));
		pending_columns.push_back(make_column(r5p_pkg::OP_READ, 16'd1, 9'd8, 32'h11111111,
			4'h3));
		pending_columns.push_back(make_column(r5p_pkg::OP_READ, 16'd2, 9'd9, 32'h22222222,
			4'h6));
		pending_columns.push_back(make_column(r5p_pkg::OP_READ, 16'd3, 9'd10, 32'hFFFFFFFF,
			4'hF));
		pending_columns.push_back(make_column(r5p_pkg::OP_READ, 16'd5, 9'd187, 32'h80402010,
			4'h1));
		pending_columns.push_back(make_column(r5p_pkg::OP_READ, 16'd5, 9'd188, 32'h80402010,
			4'h8));
		pending_columns.push_back(make_column(r5p_pkg::OP_READ, 16'hFFFF, 9'd0, 32'h01020304,
			4'h0));
		wait_drained();

		set_file_length(24'hFFFFFF);
		queue_random_columns(PHASE_WORDS);
		wait_drained();

		set_file_length(24'd1);
		send_idle_odds = 3;
		recv_idle_odds = 3;
		queue_random_columns(PHASE_WORDS / 2);
		wait_drained();
		queue_random_columns(PHASE_WORDS - PHASE_WORDS / 2);
		wait_drained();

		set_file_length(24'($urandom()));
		send_idle_odds = 12;
		recv_idle_odds = 5;
		queue_random_columns(PHASE_WORDS);
		wait_drained();

		set_file_length(24'd0);
		send_idle_odds = 5;
		recv_idle_odds = 12;
		queue_random_columns(PHASE_WORDS);
		wait_drained();

		set_file_length(24'($urandom_range(1536, 50000)));
		send_idle_odds = 8;
		recv_idle_odds = 8;
		queue_random_columns(PHASE_WORDS);
		wait_drained();

		set_file_length(24'($urandom()));
		send_idle_odds = 0;
		recv_idle_odds = 0;
		queue_random_columns(PHASE_WORDS);
		wait_drained();

		$display("covered %0d store and %0d read words over %0d file lengths", n_stores, n_reads,
			n_lengths);
		$display("rebuilt %0d single failures, flagged %0d multi-failures, %0d partial keeps",
			n_rebuilds, n_multi_fail, n_partial_keep);
		if (mismatches == 0) begin
			$display("raid5_stripe_parity_engine test passed");
		end else begin
			$display("raid5_stripe_parity_engine test failed");
		end
		$finish;
	end
endmodule
